// File: rtl/gbfp_pkg.sv
// Shared types, constants and lookup functions of the binary frame parser.
package gbfp_pkg;

  localparam int CAPTURE_BYTES_DEF = 76;
  localparam int OFF_W = 7;

  localparam logic [7:0] SYNC1_BYTE = 8'hB5;
  localparam logic [7:0] SYNC2_BYTE = 8'h62;
  localparam logic [7:0] CLASS_NAV = 8'h01;
  localparam logic [7:0] ID_PVT = 8'h07;
  localparam logic [7:0] ID_ATT = 8'h05;
  localparam logic [15:0] PVT_MIN_LEN = 16'd92;
  localparam logic [15:0] ATT_MIN_LEN = 16'd32;
  localparam logic [7:0] FIX_2D = 8'd2;

  localparam logic KIND_PVT = 1'b0;
  localparam logic KIND_ATT = 1'b1;

  localparam logic [3:0] CODE_STATUS = 4'd0;
  localparam logic [3:0] CODE_UTC = 4'd1;
  localparam logic [3:0] CODE_PVT_FIRST_WORD = 4'd2;
  localparam logic [3:0] CODE_PVT_LAST_BASE = 4'd6;
  localparam logic [3:0] CODE_PVT_LAST_VEL = 4'd13;
  localparam logic [3:0] CODE_ATT_LAST = 4'd6;

  localparam logic [1:0] PRE_LAST = 2'd3;

  typedef enum logic [3:0] {
    ST_SYNC1,
    ST_SYNC2,
    ST_HEADER,
    ST_PAYLOAD,
    ST_CKA,
    ST_CKB,
    ST_PRE_GO,
    ST_PRE_WAIT,
    ST_UTC_GO,
    ST_UTC_WAIT,
    ST_EMIT,
    ST_ITEM_GO,
    ST_ITEM_WAIT
  } state_t;

  typedef struct packed {
    logic             clr;          // sync seen: clear count and sums
    logic             hdr;          // header beat
    logic             pay;          // payload beat
    logic             fetch_start;
    logic [OFF_W-1:0] fetch_addr;
    logic             fetch_item;   // 1: item word, 0: prefetch slot
    logic [1:0]       fetch_slot;
    logic             utc_start;
    logic             item_load;
    logic             kind;
    logic [3:0]       code;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic is_b5;
    logic is_62;
    logic hdr_last;
    logic len_zero;
    logic pay_last;
    logic cka_ok;
    logic ckb_good;
    logic ckb_kind;
    logic vel;
    logic acc_nz;
    logic fetch_busy;
    logic utc_busy;
    logic out_free;
  } sts_t;

  // Payload offsets of the words read before the items: date, time, nano, and fix (accuracy for attitude frames).
  function automatic logic [OFF_W-1:0] pre_offset(input logic kind, input logic [1:0] idx);
    logic [OFF_W-1:0] off;
    case (idx)
      2'd0:    off = 7'd4;
      2'd1:    off = 7'd8;
      2'd2:    off = 7'd16;
      default: off = (kind == KIND_ATT) ? 7'd28 : 7'd20;
    endcase
    return off;
  endfunction

  function automatic logic [OFF_W-1:0] item_offset(input logic kind, input logic [3:0] code);
    logic [OFF_W-1:0] off;
    if (kind == KIND_ATT) begin
      off = OFF_W'({code, 2'b00}) + 7'd4;
    end else begin
      case (code)
        4'd2:    off = 7'd24;
        4'd3:    off = 7'd28;
        4'd4:    off = 7'd36;
        4'd5:    off = 7'd40;
        4'd6:    off = 7'd44;
        default: off = OFF_W'({code, 2'b00}) + 7'd20;
      endcase
    end
    return off;
  endfunction

  function automatic logic item_signed(input logic kind, input logic [3:0] code);
    logic s;
    if (kind == KIND_ATT) begin
      s = (code <= 4'd3);
    end else begin
      s = (code <= 4'd4) || ((code >= 4'd7) && (code <= 4'd11));
    end
    return s;
  endfunction

  // Day of year of the first of a month, year starting in March.
  function automatic logic [8:0] doy_first(input logic [3:0] m0);
    logic [8:0] d;
    case (m0)
      4'd0:    d = 9'd306;
      4'd1:    d = 9'd337;
      4'd2:    d = 9'd0;
      4'd3:    d = 9'd31;
      4'd4:    d = 9'd61;
      4'd5:    d = 9'd92;
      4'd6:    d = 9'd122;
      4'd7:    d = 9'd153;
      4'd8:    d = 9'd184;
      4'd9:    d = 9'd214;
      4'd10:   d = 9'd245;
      default: d = 9'd275;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/gbfp_utc.sv
// Multi-cycle conversion of a calendar date and time into UTC nanoseconds.
module gbfp_utc (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] date_w,
  input  logic [31:0] time_w,
  input  logic [31:0] nano_w,
  output logic        busy,
  output logic [63:0] value
);

  localparam logic [3:0] STEP_LAST = 4'd11;
  localparam logic signed [65:0] NS_MAX = 66'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [44:0] SECS_MAX = 45'sd9223372036;

  logic              busy_r;
  logic [3:0]        step_r;
  logic signed [17:0] y_r, y2_r;
  logic [3:0]        m0_r;
  logic [8:0]        doy_r;
  logic signed [8:0] era_r;
  logic [8:0]        yoe_r;
  logic signed [26:0] erad_r;
  logic [17:0]       doe_r;
  logic signed [27:0] days_r;
  logic signed [44:0] prod_r, secs_r;
  logic              neg_r, big_r;
  logic [46:0]       pl_r;
  logic signed [48:0] ph_r;
  logic [63:0]       value_r;

  logic [7:0]  month, mm1;
  logic [15:0] q_prod;
  logic [4:0]  q12;
  logic [3:0]  r12;
  logic [34:0] era_prod;
  logic signed [17:0] e400;
  logic [13:0] q100_prod;
  logic [19:0] hms;
  logic signed [65:0] sum;

  always_comb begin
    month     = date_w[23:16];
    mm1       = month - 8'd1;
    q_prod    = 16'(mm1) * 16'd171;
    q12       = q_prod[15:11];
    r12       = 4'(mm1 - 8'(q12) * 8'd12);
    era_prod  = 35'(y2_r[16:0]) * 35'd167773;
    e400      = 18'(era_r) * 18'sd400;
    q100_prod = 14'(yoe_r) * 14'd41;
    hms       = 20'(time_w[7:0]) * 20'd3600 + 20'(time_w[15:8]) * 20'd60
              + 20'(time_w[23:16]);
    sum       = $signed({ph_r, 17'b0}) + $signed({19'b0, pl_r})
              + 66'($signed(nano_w));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 4'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= 4'd1;
    end else if (busy_r) begin
      step_r <= step_r + 4'd1;
      if (step_r == STEP_LAST) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      case (step_r)
        4'd1: begin
          // month zero folds into December of the previous year
          if (month == 8'd0) begin
            y_r  <= $signed({2'b00, date_w[15:0]}) - 18'sd1;
            m0_r <= 4'd11;
          end else begin
            y_r  <= $signed({2'b00, date_w[15:0]}) + $signed({13'b0, q12});
            m0_r <= r12;
          end
        end
        4'd2: begin
          y2_r  <= (m0_r < 4'd2) ? y_r - 18'sd1 : y_r;
          doy_r <= gbfp_pkg::doy_first(m0_r);
        end
        4'd3: era_r <= y2_r[17] ? -9'sd1 : $signed(era_prod[34:26]);
        4'd4: begin
          yoe_r  <= 9'(y2_r - e400);
          erad_r <= 27'(era_r) * 27'sd146097;
        end
        4'd5: doe_r <= 18'(yoe_r) * 18'd365 + 18'(yoe_r[8:2]) - 18'(q100_prod[13:12])
                     + 18'(doy_r);
        4'd6: days_r <= 28'(erad_r) + $signed({10'b0, doe_r})
                      + $signed({20'b0, date_w[31:24]}) - 28'sd719469;
        4'd7: prod_r <= 45'(days_r) * 45'sd86400;
        4'd8: secs_r <= prod_r + $signed({25'b0, hms});
        4'd9: begin
          neg_r <= secs_r < -45'sd2;
          big_r <= secs_r > SECS_MAX;
          pl_r  <= 47'(secs_r[16:0]) * 47'd1000000000;
        end
        4'd10: ph_r <= 49'($signed(secs_r[34:17])) * 49'sd1000000000;
        4'd11: begin
          if (!time_w[26] || neg_r) value_r <= 64'd0;
          else if (big_r || sum > NS_MAX) value_r <= NS_MAX[63:0];
          else if (sum < 66'sd0) value_r <= 64'd0;
          else value_r <= sum[63:0];
        end
        default: value_r <= value_r;
      endcase
    end
  end

  assign busy  = busy_r;
  assign value = value_r;

endmodule

// File: rtl/gbfp_ctrl.sv
// Controller: frame hunt, prefetch, conversion and result sequencing.
module gbfp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gbfp_pkg::sts_t  sts,
  output gbfp_pkg::cmd_t  cmd
);

  gbfp_pkg::state_t state_r, state_nxt;
  logic       kind_r, kind_nxt;
  logic [3:0] code_r, code_nxt;
  logic [1:0] pre_r, pre_nxt;
  logic       beat, last_now, fetch_next;
  logic [3:0] code_inc;

  always_comb begin
    in_ready = (state_r == gbfp_pkg::ST_SYNC1) || (state_r == gbfp_pkg::ST_SYNC2) ||
               (state_r == gbfp_pkg::ST_HEADER) || (state_r == gbfp_pkg::ST_PAYLOAD) ||
               (state_r == gbfp_pkg::ST_CKA) || (state_r == gbfp_pkg::ST_CKB);
    beat     = in_valid && in_ready;
    code_inc = code_r + 4'd1;
    if (kind_r == gbfp_pkg::KIND_PVT) begin
      last_now   = (code_r == gbfp_pkg::CODE_PVT_LAST_VEL) ||
                   ((code_r == gbfp_pkg::CODE_PVT_LAST_BASE) && !sts.vel);
      fetch_next = code_inc >= gbfp_pkg::CODE_PVT_FIRST_WORD;
    end else begin
      last_now   = (code_r == gbfp_pkg::CODE_ATT_LAST) ||
                   ((code_r == gbfp_pkg::CODE_STATUS) && !sts.acc_nz);
      fetch_next = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    code_nxt  = code_r;
    pre_nxt   = pre_r;
    case (state_r)
      gbfp_pkg::ST_SYNC1: begin
        if (beat && sts.is_b5) state_nxt = gbfp_pkg::ST_SYNC2;
      end
      gbfp_pkg::ST_SYNC2: begin
        if (beat) begin
          if (sts.is_62) state_nxt = gbfp_pkg::ST_HEADER;
          else if (!sts.is_b5) state_nxt = gbfp_pkg::ST_SYNC1;
        end
      end
      gbfp_pkg::ST_HEADER: begin
        if (beat && sts.hdr_last)
          state_nxt = sts.len_zero ? gbfp_pkg::ST_CKA : gbfp_pkg::ST_PAYLOAD;
      end
      gbfp_pkg::ST_PAYLOAD: begin
        if (beat && sts.pay_last) state_nxt = gbfp_pkg::ST_CKA;
      end
      gbfp_pkg::ST_CKA: begin
        if (beat) state_nxt = sts.cka_ok ? gbfp_pkg::ST_CKB : gbfp_pkg::ST_SYNC1;
      end
      gbfp_pkg::ST_CKB: begin
        if (beat) begin
          if (sts.ckb_good) begin
            state_nxt = gbfp_pkg::ST_PRE_GO;
            kind_nxt  = sts.ckb_kind;
            code_nxt  = gbfp_pkg::CODE_STATUS;
            // attitude frames need only the accuracy word
            pre_nxt   = (sts.ckb_kind == gbfp_pkg::KIND_ATT) ? gbfp_pkg::PRE_LAST : 2'd0;
          end else begin
            state_nxt = gbfp_pkg::ST_SYNC1;
          end
        end
      end
      gbfp_pkg::ST_PRE_GO: state_nxt = gbfp_pkg::ST_PRE_WAIT;
      gbfp_pkg::ST_PRE_WAIT: begin
        if (!sts.fetch_busy) begin
          if (pre_r != gbfp_pkg::PRE_LAST) begin
            pre_nxt   = pre_r + 2'd1;
            state_nxt = gbfp_pkg::ST_PRE_GO;
          end else if (kind_r == gbfp_pkg::KIND_PVT) begin
            state_nxt = gbfp_pkg::ST_UTC_GO;
          end else begin
            state_nxt = gbfp_pkg::ST_EMIT;
          end
        end
      end
      gbfp_pkg::ST_UTC_GO: state_nxt = gbfp_pkg::ST_UTC_WAIT;
      gbfp_pkg::ST_UTC_WAIT: begin
        if (!sts.utc_busy) state_nxt = gbfp_pkg::ST_EMIT;
      end
      gbfp_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          if (last_now) begin
            state_nxt = gbfp_pkg::ST_SYNC1;
          end else begin
            code_nxt  = code_inc;
            state_nxt = fetch_next ? gbfp_pkg::ST_ITEM_GO : gbfp_pkg::ST_EMIT;
          end
        end
      end
      gbfp_pkg::ST_ITEM_GO: state_nxt = gbfp_pkg::ST_ITEM_WAIT;
      gbfp_pkg::ST_ITEM_WAIT: begin
        if (!sts.fetch_busy) state_nxt = gbfp_pkg::ST_EMIT;
      end
      default: state_nxt = gbfp_pkg::ST_SYNC1;
    endcase
  end

  // outputs
  always_comb begin
    cmd             = '0;
    cmd.kind        = kind_r;
    cmd.code        = code_r;
    cmd.last        = last_now;
    cmd.fetch_slot  = pre_r;
    cmd.fetch_addr  = gbfp_pkg::pre_offset(kind_r, pre_r);
    case (state_r)
      gbfp_pkg::ST_SYNC2:   cmd.clr = beat && sts.is_62;
      gbfp_pkg::ST_HEADER:  cmd.hdr = beat;
      gbfp_pkg::ST_PAYLOAD: cmd.pay = beat;
      gbfp_pkg::ST_PRE_GO:  cmd.fetch_start = 1'b1;
      gbfp_pkg::ST_UTC_GO:  cmd.utc_start = 1'b1;
      gbfp_pkg::ST_EMIT:    cmd.item_load = sts.out_free;
      gbfp_pkg::ST_ITEM_GO: begin
        cmd.fetch_start = 1'b1;
        cmd.fetch_item  = 1'b1;
        cmd.fetch_addr  = gbfp_pkg::item_offset(kind_r, code_r);
      end
      default: cmd.clr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbfp_pkg::ST_SYNC1;
      kind_r  <= gbfp_pkg::KIND_PVT;
      code_r  <= gbfp_pkg::CODE_STATUS;
      pre_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      code_r  <= code_nxt;
      pre_r   <= pre_nxt;
    end
  end

endmodule

// File: rtl/gbfp_dp.sv
// Datapath: header fields, checksum, payload memory, word fetch and output register.
module gbfp_dp #(
  parameter int CAPTURE_BYTES = gbfp_pkg::CAPTURE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     in_rx_byte,
  input  logic           out_ready,
  input  gbfp_pkg::cmd_t cmd,
  output gbfp_pkg::sts_t sts,
  output logic           out_valid,
  output logic           out_frame_kind,
  output logic [3:0]     out_item_code,
  output logic [63:0]    out_item_value,
  output logic           out_last_item
);

  localparam int AW = $clog2(CAPTURE_BYTES);

  logic [7:0]  class_r, id_r, sum_a_r, sum_b_r;
  logic [15:0] len_r, bc_r;
  logic [7:0]  sum_a_nxt;
  logic [7:0]  mem [CAPTURE_BYTES];
  logic [7:0]  rd_data_r;
  logic [AW-1:0] rd_addr;

  logic          f_busy_r, f_item_r;
  logic [1:0]    f_slot_r;
  logic [2:0]    f_cnt_r;
  logic [AW-1:0] f_base_r;
  logic [31:0]   asm_r, asm_nxt;
  logic [31:0]   slot_r [4];
  logic [31:0]   word_r;

  logic        utc_busy;
  logic [63:0] utc_value;

  logic        out_valid_r, out_kind_r, out_last_r;
  logic [3:0]  out_code_r;
  logic [63:0] out_value_r;
  logic [63:0] value;
  logic [7:0]  fix;
  logic        vel;
  logic [15:0] len_full;

  gbfp_utc u_utc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.utc_start),
    .date_w (slot_r[0]),
    .time_w (slot_r[1]),
    .nano_w (slot_r[2]),
    .busy   (utc_busy),
    .value  (utc_value)
  );

  always_comb begin
    sum_a_nxt = sum_a_r + in_rx_byte;
    len_full  = {in_rx_byte, len_r[7:0]};
    fix       = slot_r[3][7:0];
    vel       = fix >= gbfp_pkg::FIX_2D;
    rd_addr   = f_base_r + AW'(f_cnt_r[1:0]);
    asm_nxt   = {rd_data_r, asm_r[31:8]};

    sts.is_b5      = in_rx_byte == gbfp_pkg::SYNC1_BYTE;
    sts.is_62      = in_rx_byte == gbfp_pkg::SYNC2_BYTE;
    sts.hdr_last   = bc_r == 16'd3;
    sts.len_zero   = len_full == 16'd0;
    sts.pay_last   = 17'(bc_r) + 17'd1 >= 17'(len_r);
    sts.cka_ok     = in_rx_byte == sum_a_r;
    sts.ckb_good   = (in_rx_byte == sum_b_r) && (class_r == gbfp_pkg::CLASS_NAV) &&
                     (((id_r == gbfp_pkg::ID_PVT) && (len_r >= gbfp_pkg::PVT_MIN_LEN)) ||
                      ((id_r == gbfp_pkg::ID_ATT) && (len_r >= gbfp_pkg::ATT_MIN_LEN)));
    sts.ckb_kind   = (id_r == gbfp_pkg::ID_PVT) ? gbfp_pkg::KIND_PVT : gbfp_pkg::KIND_ATT;
    sts.vel        = vel;
    sts.acc_nz     = slot_r[3] != 32'd0;
    sts.fetch_busy = f_busy_r;
    sts.utc_busy   = utc_busy;
    sts.out_free   = !out_valid_r || out_ready;

    if (cmd.code == gbfp_pkg::CODE_STATUS) begin
      if (cmd.kind == gbfp_pkg::KIND_PVT)
        value = {52'b0, vel, (utc_value != 64'd0) && vel, slot_r[3][15:14], fix};
      else
        value = {63'b0, sts.acc_nz};
    end else if ((cmd.kind == gbfp_pkg::KIND_PVT) && (cmd.code == gbfp_pkg::CODE_UTC)) begin
      value = utc_value;
    end else if (gbfp_pkg::item_signed(cmd.kind, cmd.code)) begin
      value = 64'($signed(word_r));
    end else begin
      value = {32'b0, word_r};
    end
  end

  // header and checksum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_r <= 8'd0;
      id_r    <= 8'd0;
      len_r   <= 16'd0;
      bc_r    <= 16'd0;
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
    end else if (cmd.clr) begin
      bc_r    <= 16'd0;
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
    end else if (cmd.hdr || cmd.pay) begin
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_r + sum_a_nxt;
      bc_r    <= bc_r + 16'd1;
      if (cmd.hdr) begin
        case (bc_r[1:0])
          2'd0:    class_r <= in_rx_byte;
          2'd1:    id_r    <= in_rx_byte;
          2'd2:    len_r   <= {8'd0, in_rx_byte};
          default: begin
            len_r <= len_full;
            bc_r  <= 16'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pay && (bc_r < 16'(CAPTURE_BYTES))) mem[bc_r[AW-1:0]] <= in_rx_byte;
    rd_data_r <= mem[rd_addr];
  end

  // four-byte little-endian word fetch, one byte a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_busy_r <= 1'b0;
      f_cnt_r  <= 3'd0;
    end else if (cmd.fetch_start) begin
      f_busy_r <= 1'b1;
      f_cnt_r  <= 3'd0;
    end else if (f_busy_r) begin
      f_cnt_r <= f_cnt_r + 3'd1;
      if (f_cnt_r == 3'd4) f_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_start) begin
      f_base_r <= cmd.fetch_addr[AW-1:0];
      f_item_r <= cmd.fetch_item;
      f_slot_r <= cmd.fetch_slot;
    end
    if (f_busy_r && (f_cnt_r != 3'd0)) asm_r <= asm_nxt;
    if (f_busy_r && (f_cnt_r == 3'd4)) begin
      if (f_item_r) word_r <= asm_nxt;
      else slot_r[f_slot_r] <= asm_nxt;
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.item_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      out_kind_r  <= cmd.kind;
      out_code_r  <= cmd.code;
      out_value_r <= value;
      out_last_r  <= cmd.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_kind = out_kind_r;
  assign out_item_code  = out_code_r;
  assign out_item_value = out_value_r;
  assign out_last_item  = out_last_r;

endmodule

// File: rtl/gnss_binary_frame_parser_top.sv
// Top level of the binary navigation frame parser.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_rx_byte
//   out      output     out_valid/out_ready  out_frame_kind, out_item_code,
//                                            out_item_value, out_last_item
//
// in_ready stays high through every beat that does not close a frame.
// A frame that emits reads each 32-bit word through the single read port of the
// payload memory, and position frames add a date conversion before their results.
// in_ready stays low from a good ck_b beat until the last result is loaded.
// A stalled result holds the output register; reset is synchronous, active low.
module gnss_binary_frame_parser_top #(
  parameter int CAPTURE_BYTES = gbfp_pkg::CAPTURE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_kind,
  output logic [3:0]  out_item_code,
  output logic [63:0] out_item_value,
  output logic        out_last_item
);

  gbfp_pkg::cmd_t cmd;
  gbfp_pkg::sts_t sts;

  gbfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbfp_dp #(
    .CAPTURE_BYTES (CAPTURE_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_rx_byte     (in_rx_byte),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_frame_kind (out_frame_kind),
    .out_item_code  (out_item_code),
    .out_item_value (out_item_value),
    .out_last_item  (out_last_item)
  );

endmodule

// File: rtl/gbfp_checker.sv
// Port-level checks of the frame parser, bound to the top level.
module gbfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_frame_kind,
  input logic [3:0]  out_item_code,
  input logic [63:0] out_item_value,
  input logic        out_last_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_value))
    else $error("result changed while stalled");

  a_att_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_kind |-> out_item_code <= 4'd6)
    else $error("attitude item code out of range");

  a_pvt_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_item && !out_frame_kind |->
      (out_item_code == 4'd6) || (out_item_code == 4'd13))
    else $error("position frame ended on wrong item");

  a_unsigned_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_kind && (out_item_code == 4'd5) |->
      out_item_value[63:32] == 32'd0)
    else $error("accuracy not zero-extended");

endmodule

bind gnss_binary_frame_parser_top gbfp_checker u_chk (.*);
